@@ design/lae_pkg.sv @@
// Shared types and constants for the load align and extend unit.
// Holds the load kind codes, access size codes and the merge masks.
// No dependencies.
package lae_pkg;

	// Load kind carried by each item.
	typedef enum logic [3:0] {
		MODE_LB  = 4'd0,
		MODE_LBU = 4'd1,
		MODE_LH  = 4'd2,
		MODE_LHU = 4'd3,
		MODE_LW  = 4'd4,
		MODE_LWU = 4'd5,
		MODE_LWL = 4'd6,
		MODE_LWR = 4'd7,
		MODE_LD  = 4'd8,
		MODE_LDL = 4'd9,
		MODE_LDR = 4'd10,
		MODE_LUI = 4'd11
	} lae_mode_t;

	// Access size reported with each result item.
	typedef enum logic [2:0] {
		SZ_NONE  = 3'd0,
		SZ_BYTE  = 3'd1,
		SZ_HALF  = 3'd2,
		SZ_WORD  = 3'd3,
		SZ_DWORD = 3'd4
	} lae_size_t;

	// Address side decode handed to the top level.
	typedef struct packed {
		logic [31:0] addr;
		lae_size_t   size;
		logic        valid;
		logic        lui;
	} lae_ctl_t;

	localparam logic [63:0] DW_LEFT_KEEP_C  = 64'h00FF_FFFF_FFFF_FFFF;
	localparam logic [63:0] DW_RIGHT_KEEP_C = 64'hFFFF_FFFF_FFFF_FF00;
	localparam logic [31:0] W_LEFT_KEEP_C   = 32'h00FF_FFFF;
	localparam logic [31:0] W_RIGHT_KEEP_C  = 32'hFFFF_FF00;
	localparam logic [31:0] DW_ALIGN_C      = 32'hFFFF_FFF8;
	localparam logic [31:0] W_ALIGN_C       = 32'hFFFF_FFFC;

endpackage

@@ design/lae_addr.sv @@
// Address generation and access size decode for the load unit.
// Depends on lae_pkg for the load kinds, size codes and alignment masks.
module lae_addr (
	input  logic [3:0]        mode,
	input  logic [31:0]       base_word,
	input  logic signed [15:0] offset,
	output logic [2:0]        va_low,
	output lae_pkg::lae_ctl_t ctl
);

	logic [31:0] va;

	// Base plus sign-extended offset, wrapping at 32 bits.
	assign va     = base_word + {{16{offset[15]}}, offset};
	assign va_low = va[2:0];

	// Decode address alignment and size from the load kind.
	always_comb begin
		ctl.addr  = va;
		ctl.size  = lae_pkg::SZ_NONE;
		ctl.valid = 1'b1;
		ctl.lui   = 1'b0;
		unique case (lae_pkg::lae_mode_t'(mode))
			lae_pkg::MODE_LB, lae_pkg::MODE_LBU: begin
				ctl.size = lae_pkg::SZ_BYTE;
			end
			lae_pkg::MODE_LH, lae_pkg::MODE_LHU: begin
				ctl.size = lae_pkg::SZ_HALF;
			end
			lae_pkg::MODE_LW, lae_pkg::MODE_LWU: begin
				ctl.size = lae_pkg::SZ_WORD;
			end
			lae_pkg::MODE_LWL, lae_pkg::MODE_LWR: begin
				ctl.addr = va & lae_pkg::W_ALIGN_C;
				ctl.size = lae_pkg::SZ_WORD;
			end
			lae_pkg::MODE_LD: begin
				ctl.size = lae_pkg::SZ_DWORD;
			end
			lae_pkg::MODE_LDL, lae_pkg::MODE_LDR: begin
				ctl.addr = va & lae_pkg::DW_ALIGN_C;
				ctl.size = lae_pkg::SZ_DWORD;
			end
			lae_pkg::MODE_LUI: begin
				ctl.addr = 32'd0;
				ctl.lui  = 1'b1;
			end
			default: begin
				ctl.addr  = 32'd0;
				ctl.valid = 1'b0;
			end
		endcase
	end

endmodule

@@ design/lae_merge.sv @@
// Data path of the load unit: extension, left/right merges and upper immediate.
// Depends on lae_pkg for the load kinds and merge masks.
module lae_merge (
	input  logic [3:0]         mode,
	input  logic [2:0]         va_low,
	input  logic signed [15:0] offset,
	input  logic [63:0]        mem_data,
	input  logic [63:0]        dest_old,
	output logic [63:0]        value
);

	logic [4:0]  sh4;
	logic [5:0]  sh8;
	logic [31:0] oldw;
	logic [31:0] mw;
	logic [31:0] wl;
	logic [31:0] wr;
	logic [31:0] wr_keep;
	logic [63:0] dl;
	logic [63:0] dr;
	logic [63:0] dr_keep;

	assign sh4  = {va_low[1:0], 3'b000};
	assign sh8  = {va_low, 3'b000};
	assign oldw = dest_old[31:0];
	assign mw   = mem_data[31:0];

	// Word merges: bytes of memory shifted into the old low word.
	assign wl      = (oldw & (lae_pkg::W_LEFT_KEEP_C >> sh4)) | (mw << (5'd24 - sh4));
	assign wr_keep = (sh4 == 5'd0) ? 32'd0 : (lae_pkg::W_RIGHT_KEEP_C << (5'd24 - sh4));
	assign wr      = (oldw & wr_keep) | (mw >> sh4);

	// Doubleword merges with the whole old value.
	assign dl      = (dest_old & (lae_pkg::DW_LEFT_KEEP_C >> sh8)) | (mem_data << (6'd56 - sh8));
	assign dr_keep = (sh8 == 6'd0) ? 64'd0 : (lae_pkg::DW_RIGHT_KEEP_C << (6'd56 - sh8));
	assign dr      = (dest_old & dr_keep) | (mem_data >> sh8);

	// Select the new destination value by load kind.
	always_comb begin
		value = dest_old;
		unique case (lae_pkg::lae_mode_t'(mode))
			lae_pkg::MODE_LB:  value = {{56{mem_data[7]}}, mem_data[7:0]};
			lae_pkg::MODE_LBU: value = {56'd0, mem_data[7:0]};
			lae_pkg::MODE_LH:  value = {{48{mem_data[15]}}, mem_data[15:0]};
			lae_pkg::MODE_LHU: value = {48'd0, mem_data[15:0]};
			lae_pkg::MODE_LW:  value = {{32{mw[31]}}, mw};
			lae_pkg::MODE_LWU: value = {32'd0, mw};
			lae_pkg::MODE_LWL: value = {{32{wl[31]}}, wl};
			lae_pkg::MODE_LWR: begin
				// An aligned right merge loads the whole word, sign-extended.
				if (sh4 == 5'd0) begin
					value = {{32{wr[31]}}, wr};
				end else begin
					value = {dest_old[63:32], wr};
				end
			end
			lae_pkg::MODE_LD:  value = mem_data;
			lae_pkg::MODE_LDL: value = dl;
			lae_pkg::MODE_LDR: value = dr;
			lae_pkg::MODE_LUI: value = {{32{offset[15]}}, offset, 16'd0};
			default:           value = dest_old;
		endcase
	end

endmodule

@@ design/load_align_extend_unit.sv @@
// Top level of the load align and extend unit: input register, decode and
// merge logic, result register. Depends on lae_pkg, lae_addr and lae_merge.
//
// Channel   Direction  Handshake          Payload
// command   in         start, busy        mode, base_word, offset, mem_data,
//                                         dest_old, translation_fault
// result    out        done (strobe)      mem_address, access_size,
//                                         write_enable, dest_value
//
// One item is accepted every cycle; busy is never raised.
// Each result appears on done once its item has passed the input register
// and then the address and merge logic into the result register.
// Reset clears the stage valid flags only; payload registers are not reset.
// Results are held for one cycle only, as the receiver cannot stall.
module load_align_extend_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [3:0]         mode,
	input  logic [31:0]        base_word,
	input  logic signed [15:0] offset,
	input  logic [63:0]        mem_data,
	input  logic [63:0]        dest_old,
	input  logic               translation_fault,
	output logic               done,
	output logic [31:0]        mem_address,
	output logic [2:0]         access_size,
	output logic               write_enable,
	output logic [63:0]        dest_value
);

	logic               valid_s1;
	logic [3:0]         mode_s1;
	logic [31:0]        base_s1;
	logic signed [15:0] offset_s1;
	logic [63:0]        mem_s1;
	logic [63:0]        old_s1;
	logic               fault_s1;

	logic               valid_s2;
	logic [31:0]        addr_s2;
	logic [2:0]         size_s2;
	logic               we_s2;
	logic [63:0]        value_s2;

	lae_pkg::lae_ctl_t  ctl;
	logic [2:0]         va_low;
	logic [63:0]        merged;
	logic               we;

	assign busy = 1'b0;

	// Input register: capture an item whenever one is accepted.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			mode_s1   <= mode;
			base_s1   <= base_word;
			offset_s1 <= offset;
			mem_s1    <= mem_data;
			old_s1    <= dest_old;
			fault_s1  <= translation_fault;
		end
	end

	lae_addr u_addr (
		.mode      (mode_s1),
		.base_word (base_s1),
		.offset    (offset_s1),
		.va_low    (va_low),
		.ctl       (ctl)
	);

	lae_merge u_merge (
		.mode     (mode_s1),
		.va_low   (va_low),
		.offset   (offset_s1),
		.mem_data (mem_s1),
		.dest_old (old_s1),
		.value    (merged)
	);

	// A fault suppresses the write except for the upper-immediate form.
	assign we = ctl.valid && (ctl.lui || !fault_s1);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			addr_s2  <= ctl.addr;
			size_s2  <= ctl.size;
			we_s2    <= we;
			value_s2 <= we ? merged : old_s1;
		end
	end

	assign done         = valid_s2;
	assign mem_address  = addr_s2;
	assign access_size  = size_s2;
	assign write_enable = we_s2;
	assign dest_value   = value_s2;

	// Every accepted item yields a result through the input and result registers, and nothing else does.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> ##1 done)
		else $error("accepted item produced no result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		(!(start && !busy)) |=> ##1 !done)
		else $error("result strobe without an accepted item");

	// No memory access means no address is driven.
	a_none_zero_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(done && access_size == lae_pkg::SZ_NONE) |-> mem_address == 32'd0)
		else $error("address driven for an item with no access");

	// A suppressed write leaves the destination value unchanged.
	a_suppress_keeps_old: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !write_enable) |-> dest_value == $past(dest_old, 2))
		else $error("suppressed write changed the destination value");

endmodule

@@ sim/load_align_extend_unit_test.sv @@
// Self-checking testbench for the load align and extend unit.
// Drives load items, predicts address, size, write enable and value, and checks them.
// Depends on lae_pkg and load_align_extend_unit.
module load_align_extend_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 20000;
	localparam int TAIL_CYCLES = 6;
	localparam int RANDOM_LOADS = 500;
	localparam logic [3:0] MODE_UNDEF_LO = 4'd12;
	localparam logic [3:0] MODE_UNDEF_HI = 4'd15;

	typedef struct {
		logic [3:0]         mode;
		logic [31:0]        base;
		logic signed [15:0] offset;
		logic [63:0]        mem;
		logic [63:0]        old;
		logic               fault;
	} load_item_t;

	typedef struct {
		logic [31:0]        addr;
		lae_pkg::lae_size_t size;
		logic               we;
		logic [63:0]        value;
	} load_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic [3:0]         mode = '0;
	logic [31:0]        base_word = '0;
	logic signed [15:0] offset = '0;
	logic [63:0]        mem_data = '0;
	logic [63:0]        dest_old = '0;
	logic               translation_fault = 1'b0;
	logic               done;
	logic [31:0]        mem_address;
	logic [2:0]         access_size;
	logic               write_enable;
	logic [63:0]        dest_value;

	load_item_t   pending_loads[$];
	load_result_t expected_loads[$];
	load_item_t   driven_load;
	load_result_t seen_load;
	int           accepted_count = 0;
	int           error_count = 0;
	int           cycle_count = 0;
	logic         gap;

	load_align_extend_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.mode(mode),
		.base_word(base_word),
		.offset(offset),
		.mem_data(mem_data),
		.dest_old(dest_old),
		.translation_fault(translation_fault),
		.done(done),
		.mem_address(mem_address),
		.access_size(access_size),
		.write_enable(write_enable),
		.dest_value(dest_value)
	);

	always #5 clk = ~clk;

	// Works out address, size, write enable and new destination value of one load.
	function automatic load_result_t predict_load(load_item_t it);
		load_result_t r;
		logic [31:0]  imm32;
		logic [31:0]  va;
		logic [31:0]  mw;
		logic [31:0]  ow;
		logic [31:0]  w;
		logic [31:0]  keep32;
		logic [63:0]  keep64;
		logic [5:0]   sh4;
		logic [6:0]   sh8;
		logic         legal;
		logic         ignore_fault;
		imm32 = {{16{it.offset[15]}}, it.offset};
		va = it.base + imm32;
		mw = it.mem[31:0];
		ow = it.old[31:0];
		sh4 = {1'b0, va[1:0], 3'b000};
		sh8 = {1'b0, va[2:0], 3'b000};
		legal = 1'b1;
		ignore_fault = 1'b0;
		r.addr = va;
		r.size = lae_pkg::SZ_NONE;
		r.value = it.old;
		case (it.mode)
			lae_pkg::MODE_LB: begin
				r.size = lae_pkg::SZ_BYTE;
				r.value = {{56{it.mem[7]}}, it.mem[7:0]};
			end
			lae_pkg::MODE_LBU: begin
				r.size = lae_pkg::SZ_BYTE;
				r.value = {56'd0, it.mem[7:0]};
			end
			lae_pkg::MODE_LH: begin
				r.size = lae_pkg::SZ_HALF;
				r.value = {{48{it.mem[15]}}, it.mem[15:0]};
			end
			lae_pkg::MODE_LHU: begin
				r.size = lae_pkg::SZ_HALF;
				r.value = {48'd0, it.mem[15:0]};
			end
			lae_pkg::MODE_LW: begin
				r.size = lae_pkg::SZ_WORD;
				r.value = {{32{mw[31]}}, mw};
			end
			lae_pkg::MODE_LWU: begin
				r.size = lae_pkg::SZ_WORD;
				r.value = {32'd0, mw};
			end
			lae_pkg::MODE_LWL: begin
				w = (ow & (lae_pkg::W_LEFT_KEEP_C >> sh4)) | (mw << (6'd24 - sh4));
				r.addr = va & lae_pkg::W_ALIGN_C;
				r.size = lae_pkg::SZ_WORD;
				r.value = {{32{w[31]}}, w};
			end
			lae_pkg::MODE_LWR: begin
				keep32 = (sh4 == 0) ? 32'd0 :
					(lae_pkg::W_RIGHT_KEEP_C << (6'd24 - sh4));
				w = (ow & keep32) | (mw >> sh4);
				r.addr = va & lae_pkg::W_ALIGN_C;
				r.size = lae_pkg::SZ_WORD;
				// An aligned right merge loads the whole word and sign-extends it.
				if (sh4 == 0) begin
					r.value = {{32{w[31]}}, w};
				end else begin
					r.value = {it.old[63:32], w};
				end
			end
			lae_pkg::MODE_LD: begin
				r.size = lae_pkg::SZ_DWORD;
				r.value = it.mem;
			end
			lae_pkg::MODE_LDL: begin
				r.addr = va & lae_pkg::DW_ALIGN_C;
				r.size = lae_pkg::SZ_DWORD;
				r.value = (it.old & (lae_pkg::DW_LEFT_KEEP_C >> sh8)) |
					(it.mem << (7'd56 - sh8));
			end
			lae_pkg::MODE_LDR: begin
				keep64 = (sh8 == 0) ? 64'd0 :
					(lae_pkg::DW_RIGHT_KEEP_C << (7'd56 - sh8));
				r.addr = va & lae_pkg::DW_ALIGN_C;
				r.size = lae_pkg::SZ_DWORD;
				r.value = (it.old & keep64) | (it.mem >> sh8);
			end
			lae_pkg::MODE_LUI: begin
				// No memory access, so a translation fault cannot stop the write.
				r.addr = '0;
				r.size = lae_pkg::SZ_NONE;
				r.value = {{32{it.offset[15]}}, it.offset, 16'd0};
				ignore_fault = 1'b1;
			end
			default: begin
				legal = 1'b0;
				r.addr = '0;
				r.size = lae_pkg::SZ_NONE;
			end
		endcase
		r.we = legal && (ignore_fault || !it.fault);
		if (!r.we) begin
			r.value = it.old;
		end
		return r;
	endfunction

	function automatic load_item_t make_load(logic [3:0] m, logic [31:0] b,
			logic signed [15:0] o, logic [63:0] md, logic [63:0] od, logic f);
		load_item_t it;
		it.mode = m;
		it.base = b;
		it.offset = o;
		it.mem = md;
		it.old = od;
		it.fault = f;
		return it;
	endfunction

	// Random load, mostly legal kinds, with base values pushed to the extremes now and then.
	task automatic add_random_load();
		load_item_t it;
		if ($urandom_range(99) < 5) begin
			it.mode = 4'($urandom_range(MODE_UNDEF_HI, MODE_UNDEF_LO));
		end else begin
			it.mode = 4'($urandom_range(lae_pkg::MODE_LUI, lae_pkg::MODE_LB));
		end
		case ($urandom_range(7))
			0: it.base = 32'hFFFF_FFFF - 32'($urandom_range(15));
			1: it.base = 32'($urandom_range(15));
			default: it.base = $urandom;
		endcase
		it.offset = 16'($urandom);
		it.mem = {$urandom, $urandom};
		it.old = {$urandom, $urandom};
		it.fault = ($urandom_range(9) == 0);
		pending_loads.push_back(it);
	endtask

	task automatic report_mismatch(string what);
		$display("[%0t] mismatch: %s", $realtime, what);
		error_count++;
	endtask

	// Driver: records each accepted item, then offers the next one unless idling.
	always @(posedge clk) begin
		if (start && !busy) begin
			expected_loads.push_back(predict_load(driven_load));
			accepted_count++;
		end
		gap = (accepted_count < 150 || accepted_count >= 300) && ($urandom_range(99) < 12);
		if (start && busy) begin
			start <= 1'b1;
		end else if (arst_n && pending_loads.size() > 0 && !gap) begin
			driven_load = pending_loads.pop_front();
			start <= 1'b1;
			mode <= driven_load.mode;
			base_word <= driven_load.base;
			offset <= driven_load.offset;
			mem_data <= driven_load.mem;
			dest_old <= driven_load.old;
			translation_fault <= driven_load.fault;
		end else begin
			start <= 1'b0;
		end
	end

	// Monitor: every strobed result is checked against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_loads.size() == 0) begin
				report_mismatch("result item with no load outstanding");
			end else begin
				seen_load = expected_loads.pop_front();
				if (mem_address !== seen_load.addr)
					report_mismatch($sformatf("mem_address %h, expected %h",
						mem_address, seen_load.addr));
				if (access_size !== seen_load.size)
					report_mismatch($sformatf("access_size %0d, expected %0d",
						access_size, seen_load.size));
				if (write_enable !== seen_load.we)
					report_mismatch($sformatf("write_enable %b, expected %b",
						write_enable, seen_load.we));
				if (dest_value !== seen_load.value)
					report_mismatch($sformatf("dest_value %h, expected %h",
						dest_value, seen_load.value));
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		// Directed loads: sign edges, address wrap, end merge alignments (all four for LWR), faults, odd kinds.
		pending_loads.push_back(make_load(lae_pkg::MODE_LB, 32'h0, 16'sd0,
			64'h80, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0));
		pending_loads.push_back(make_load(lae_pkg::MODE_LB, 32'h0, 16'sd1,
			64'hFFFF_FFFF_FFFF_FF7F, 64'h0, 1'b0));
		pending_loads.push_back(make_load(lae_pkg::MODE_LBU, 32'h1234, -16'sd1,
			64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 1'b0));
		pending_loads.push_back(make_load(lae_pkg::MODE_LH, 32'hFFFF_FFFF, 16'sd32767,
			64'h8000, 64'h0, 1'b0));
		pending_loads.push_back(make_load(lae_pkg::MODE_LHU, 32'h8000_0001, -16'sd32768,
			64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 1'b0));
		pending_loads.push_back(make_load(lae_pkg::MODE_LW, 32'h0, -16'sd32768,
			64'h0000_0000_8000_0000, 64'h5555_5555_5555_5555, 1'b0));
		pending_loads.push_back(make_load(lae_pkg::MODE_LWU, 32'hFFFF_FFFF, 16'sd1,
			64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 1'b0));
		pending_loads.push_back(make_load(lae_pkg::MODE_LWL, 32'h1000_0000, 16'sd0,
			64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 1'b0));
		pending_loads.push_back(make_load(lae_pkg::MODE_LWL, 32'h1000_0000, 16'sd3,
			64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 1'b0));
		for (int k = 0; k < 4; k++) begin
			pending_loads.push_back(make_load(lae_pkg::MODE_LWR, 32'h2000_0000 + k,
				16'sd0, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 1'b0));
		end
		pending_loads.push_back(make_load(lae_pkg::MODE_LD, 32'hFFFF_FFF8, 16'sd8,
			64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 1'b0));
		pending_loads.push_back(make_load(lae_pkg::MODE_LDL, 32'h3000_0000, 16'sd0,
			64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 1'b0));
		pending_loads.push_back(make_load(lae_pkg::MODE_LDL, 32'h3000_0000, 16'sd7,
			64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 1'b0));
		pending_loads.push_back(make_load(lae_pkg::MODE_LDR, 32'h3000_0000, 16'sd0,
			64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 1'b0));
		pending_loads.push_back(make_load(lae_pkg::MODE_LDR, 32'h3000_0007, 16'sd0,
			64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 1'b0));
		pending_loads.push_back(make_load(lae_pkg::MODE_LUI, 32'hDEAD_BEEF, -16'sd32768,
			64'h0, 64'h1111_1111_1111_1111, 1'b1));
		pending_loads.push_back(make_load(lae_pkg::MODE_LUI, 32'h0, 16'sd32767,
			64'h0, 64'h0, 1'b0));
		pending_loads.push_back(make_load(lae_pkg::MODE_LW, 32'h4000_0000, 16'sd4,
			64'hFFFF_FFFF_FFFF_FFFF, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1));
		pending_loads.push_back(make_load(MODE_UNDEF_LO, 32'h4000_0000, 16'sd4,
			64'hFFFF_FFFF_FFFF_FFFF, 64'h1234_5678_9ABC_DEF0, 1'b0));
		pending_loads.push_back(make_load(MODE_UNDEF_HI, 32'hFFFF_FFFF, -16'sd1,
			64'hFFFF_FFFF_FFFF_FFFF, 64'h0F0F_0F0F_0F0F_0F0F, 1'b1));
		for (int n = 0; n < RANDOM_LOADS; n++) begin
			add_random_load();
		end

		// Reset once, then let the driver and monitor run.
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_loads.size() > 0 || start) begin
			@(posedge clk);
		end
		while (expected_loads.size() > 0) begin
			@(posedge clk);
		end
		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_loads.size() != 0) begin
			report_mismatch("load results still outstanding at the end");
		end
		if (error_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end
endmodule
